// ===== hdl/imrle_pkg.sv =====
// Shared types and constants of the image run-length encoder.
package imrle_pkg;

	localparam int ROW_W  = 10;
	localparam int COL_W  = 10;
	localparam int VAL_W  = 8;
	localparam int LEN_W  = 21;
	localparam int CFG_W  = 11;
	localparam int CFG_IDX_W = 2;
	localparam int SIZE_W = 17;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int TDATA_W = 56;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NUM_ROWS  = 2'd0,
		CFG_NUM_COLS  = 2'd1,
		CFG_SKIP_ZERO = 2'd2,
		CFG_WRAP_ROWS = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [VAL_W-1:0] value;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} run_t;

	// One entry of the command queue: up to two runs and the end-of-image flag.
	typedef struct packed {
		logic emit_a;
		run_t a;
		logic emit_b;
		run_t b;
		logic done;
	} cmd_t;

endpackage

// ===== hdl/image_run_length_encoder_unit.sv =====
// Top level of the image run-length encoder.
// Pixels enter in raster order at one transaction per cycle; each pixel is
// classified on acceptance by the front end, which updates the open run
// and queues a command only when runs or the end-of-image marker must go out.
// The output stage sends one run per cycle while m_tready allows, so a pixel that
// closes two runs costs two output transactions; a four-entry command queue absorbs
// such bursts and output stalls, and input is held off only while that queue is full.
// A pixel's first run goes through the command queue and then the output register.
module image_run_length_encoder_unit #(
	parameter int MAX_ROWS   = 1024,
	parameter int MAX_COLS   = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [imrle_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [imrle_pkg::CFG_W-1:0]      cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [imrle_pkg::VAL_W-1:0]      s_tdata,  // pixel_value
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// run_row, run_start_col, run_value, run_length, zero fill
	output logic [imrle_pkg::TDATA_W-1:0]    m_tdata,
	output logic                             m_tuser,  // run_valid
	output logic                             m_tlast   // image_done
);
	import imrle_pkg::*;

	logic q_full, q_push, q_pop, q_head_valid;
	cmd_t q_cmd, q_head;

	imrle_front #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	imrle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_cmd   (q_head)
	);

	imrle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_cmd   (q_head),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// ===== hdl/imrle_front.sv =====
// Front end: accepts pixels, tracks the open run and classifies emitted runs.
module imrle_front #(
	parameter int MAX_ROWS   = 1024,
	parameter int MAX_COLS   = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [imrle_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [imrle_pkg::CFG_W-1:0]  cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [imrle_pkg::VAL_W-1:0]  s_tdata,
	input  logic                         q_full,
	output logic                         q_push,
	output imrle_pkg::cmd_t              q_cmd
);
	import imrle_pkg::*;

	localparam logic [VAL_W-1:0] PX_MASK =
		(PIXEL_BITS >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((1 << PIXEL_BITS) - 1);
	localparam logic [SIZE_W-1:0] MAX_ROWS_C = SIZE_W'(MAX_ROWS);
	localparam logic [SIZE_W-1:0] MAX_COLS_C = SIZE_W'(MAX_COLS);

	logic [CFG_W-1:0] num_rows_q, num_cols_q;
	logic             skip_zero_q, wrap_rows_q;
	logic [ROW_W-1:0] row_pos_q;
	logic [COL_W-1:0] col_pos_q;
	logic             run_open_q;
	run_t             cur_q;

	logic [SIZE_W-1:0] rows_c, cols_c, nr_ext, nc_ext;
	logic              row_end, img_end, match, flush, accept;
	logic [VAL_W-1:0]  px;
	run_t              nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q  <= CFG_W'(1);
			num_cols_q  <= CFG_W'(1);
			skip_zero_q <= 1'b0;
			wrap_rows_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_idx))
				CFG_NUM_ROWS:  num_rows_q  <= cfg_data;
				CFG_NUM_COLS:  num_cols_q  <= cfg_data;
				CFG_SKIP_ZERO: skip_zero_q <= cfg_data[0];
				CFG_WRAP_ROWS: wrap_rows_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		nr_ext = SIZE_W'(num_rows_q);
		nc_ext = SIZE_W'(num_cols_q);
		if (nr_ext == '0)
			rows_c = SIZE_W'(1);
		else if (nr_ext > MAX_ROWS_C)
			rows_c = MAX_ROWS_C;
		else
			rows_c = nr_ext;
		if (nc_ext == '0)
			cols_c = SIZE_W'(1);
		else if (nc_ext > MAX_COLS_C)
			cols_c = MAX_COLS_C;
		else
			cols_c = nc_ext;
	end

	assign px      = s_tdata & PX_MASK;
	assign row_end = SIZE_W'(col_pos_q) >= (cols_c - SIZE_W'(1));
	assign img_end = row_end && (SIZE_W'(row_pos_q) >= (rows_c - SIZE_W'(1)));
	assign match   = run_open_q && (px == cur_q.value);
	assign flush   = img_end || (row_end && !wrap_rows_q);
	assign s_tready = !q_full;
	assign accept  = s_tvalid && s_tready;

	always_comb begin
		if (match) begin
			nxt = cur_q;
			if (cur_q.len != LEN_MAX)
				nxt.len = cur_q.len + LEN_W'(1);
		end else begin
			nxt.value = px;
			nxt.row   = row_pos_q;
			nxt.col   = col_pos_q;
			nxt.len   = LEN_W'(1);
		end
	end

	always_comb begin
		q_cmd.emit_a = run_open_q && !match && !(skip_zero_q && cur_q.value == '0);
		q_cmd.a      = cur_q;
		q_cmd.emit_b = flush && !(skip_zero_q && nxt.value == '0);
		q_cmd.b      = nxt;
		q_cmd.done   = img_end;
		q_push       = accept && (q_cmd.emit_a || q_cmd.emit_b || img_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q  <= '0;
			col_pos_q  <= '0;
			run_open_q <= 1'b0;
			cur_q      <= '0;
		end else if (accept) begin
			cur_q      <= nxt;
			run_open_q <= !flush;
			if (img_end) begin
				row_pos_q <= '0;
				col_pos_q <= '0;
			end else if (row_end) begin
				col_pos_q <= '0;
				row_pos_q <= row_pos_q + ROW_W'(1);
			end else begin
				col_pos_q <= col_pos_q + COL_W'(1);
			end
		end
	end

endmodule

// ===== hdl/imrle_queue.sv =====
// Short command queue between the front end and the output stage.
module imrle_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  imrle_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output imrle_pkg::cmd_t head_cmd
);
	import imrle_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_pop;

	assign full       = count_q == (QPTR_W+1)'(QDEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !do_pop)
				count_q <= count_q + (QPTR_W+1)'(1);
			else if (do_pop && !push)
				count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

endmodule

// ===== hdl/imrle_back.sv =====
// Back end: expands queued commands into output transactions.
module imrle_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  imrle_pkg::cmd_t               head_cmd,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [imrle_pkg::TDATA_W-1:0] m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast
);
	import imrle_pkg::*;

	logic phase_q, m_tvalid_q, m_tuser_q, m_tlast_q;
	run_t run_q;
	logic sel_a, load, item_valid, item_last;
	run_t item;

	assign sel_a = !phase_q && head_cmd.emit_a;
	assign load  = head_valid && (!m_tvalid_q || m_tready);
	assign pop   = load && !(sel_a && head_cmd.emit_b);

	always_comb begin
		if (sel_a) begin
			item       = head_cmd.a;
			item_valid = 1'b1;
			item_last  = head_cmd.done && !head_cmd.emit_b;
		end else if (head_cmd.emit_b) begin
			item       = head_cmd.b;
			item_valid = 1'b1;
			item_last  = head_cmd.done;
		end else begin
			item       = '0;
			item_valid = 1'b0;
			item_last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q    <= sel_a && head_cmd.emit_b;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q     <= item;
			m_tuser_q <= item_valid;
			m_tlast_q <= item_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(run_q);
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the image run-length encoder with a run-predicting scoreboard.
module testbench;
	import imrle_pkg::*;

	localparam int SIZE_LIMIT = 1024;
	localparam int PIXEL_TARGET = 1450;
	localparam int QUIET_AT = 1250;
	localparam int LONG_HOLD = 300;
	localparam int SETTLE = 8;
	localparam int MAX_BURST = 18;
	localparam int PAD_LSB = ROW_W + COL_W + VAL_W + LEN_W;

	typedef struct packed {
		logic             valid;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [VAL_W-1:0] value;
		logic [LEN_W-1:0] len;
		logic             done;
	} run_rec_t;

	class run_scoreboard;
		int unsigned num_rows, num_cols;
		bit skip_zero, wrap_rows;
		int unsigned row_pos, col_pos, start_row, start_col, run_len;
		logic [VAL_W-1:0] run_val;
		bit run_open;
		run_rec_t expected_runs[$];
		int errors;

		function new();
			num_rows = 1;
			num_cols = 1;
			skip_zero = 0;
			wrap_rows = 0;
			row_pos = 0;
			col_pos = 0;
			start_row = 0;
			start_col = 0;
			run_len = 0;
			run_val = '0;
			run_open = 0;
			errors = 0;
		endfunction

		function int unsigned clamp_size(int unsigned v);
			if (v == 0)
				return 1;
			if (v > SIZE_LIMIT)
				return SIZE_LIMIT;
			return v;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_NUM_ROWS: num_rows = 32'(data);
				CFG_NUM_COLS: num_cols = 32'(data);
				CFG_SKIP_ZERO: skip_zero = data[0];
				CFG_WRAP_ROWS: wrap_rows = data[0];
				default: ;
			endcase
		endfunction

		function void close_run();
			run_rec_t r;
			if (skip_zero && run_val == '0)
				return;
			r = '0;
			r.valid = 1'b1;
			r.row = start_row[ROW_W-1:0];
			r.col = start_col[COL_W-1:0];
			r.value = run_val;
			r.len = run_len[LEN_W-1:0];
			expected_runs.push_back(r);
		endfunction

		function void note_pixel(logic [VAL_W-1:0] px);
			int unsigned rows, cols, count_prior;
			bit row_end, img_end;
			run_rec_t last;
			rows = clamp_size(num_rows);
			cols = clamp_size(num_cols);
			row_end = col_pos >= cols - 1;
			img_end = row_end && row_pos >= rows - 1;
			count_prior = expected_runs.size();
			if (run_open && px == run_val) begin
				if (run_len < LEN_MAX)
					run_len++;
			end else begin
				if (run_open)
					close_run();
				run_open = 1;
				run_val = px;
				start_row = row_pos;
				start_col = col_pos;
				run_len = 1;
			end
			if (img_end || (row_end && !wrap_rows)) begin
				close_run();
				run_open = 0;
			end
			if (img_end) begin
				if (expected_runs.size() == count_prior)
					last = '0;
				else
					last = expected_runs.pop_back();
				last.done = 1'b1;
				expected_runs.push_back(last);
				row_pos = 0;
				col_pos = 0;
			end else if (row_end) begin
				col_pos = 0;
				row_pos = (row_pos + 1) & 32'h3FF;
			end else begin
				col_pos = (col_pos + 1) & 32'h3FF;
			end
		endfunction

		function void flag(string what, run_rec_t want, run_rec_t got,
				logic [TDATA_W-1:0] data);
			errors++;
			if (errors <= 10)
				$display({"%s: expected valid=%0d row=%0d col=%0d value=%0d len=%0d done=%0d,",
					" got valid=%0d row=%0d col=%0d value=%0d len=%0d done=%0d tdata=%h"},
					what, want.valid, want.row, want.col, want.value, want.len, want.done,
					got.valid, got.row, got.col, got.value, got.len, got.done, data);
		endfunction

		function void check_run(logic valid, logic [TDATA_W-1:0] data, logic done);
			run_rec_t got, want;
			got.valid = valid;
			got.row = data[ROW_W-1:0];
			got.col = data[ROW_W +: COL_W];
			got.value = data[ROW_W+COL_W +: VAL_W];
			got.len = data[ROW_W+COL_W+VAL_W +: LEN_W];
			got.done = done;
			if (expected_runs.size() == 0) begin
				flag("unexpected run", '0, got, data);
				return;
			end
			want = expected_runs.pop_front();
			if (got !== want || data[TDATA_W-1:PAD_LSB] !== '0)
				flag("run mismatch", want, got, data);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [VAL_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [TDATA_W-1:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	run_scoreboard sb;
	bit quiet = 0;
	bit hold_request = 0;
	bit hold_active = 0;
	int pixels_sent = 0;

	image_run_length_encoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_run(m_tuser, m_tdata, m_tlast);
	end

	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_active = 1;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 0;
				hold_active = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	task automatic send_pixel(input logic [VAL_W-1:0] px);
		if (!quiet && $urandom_range(0, 6) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		sb.note_pixel(px);
		pixels_sent++;
	endtask

	task automatic wait_for_runs();
		s_tvalid <= 1'b0;
		while (sb.expected_runs.size() != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
		cfg_idx <= idx;
		cfg_data <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	task automatic set_config(input int unsigned rows, input int unsigned cols,
			input bit skip, input bit wrap);
		wait_for_runs();
		cfg_we <= 1'b1;
		write_reg(CFG_NUM_ROWS, rows[CFG_W-1:0]);
		write_reg(CFG_NUM_COLS, cols[CFG_W-1:0]);
		write_reg(CFG_SKIP_ZERO, {{(CFG_W-1){1'b0}}, skip});
		write_reg(CFG_WRAP_ROWS, {{(CFG_W-1){1'b0}}, wrap});
		cfg_we <= 1'b0;
	endtask

	// Mostly repeats the previous value so that runs of useful length form.
	function automatic logic [VAL_W-1:0] pick_pixel(input logic [VAL_W-1:0] prev);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return prev;
			5, 6: return '0;
			7: return '1;
			default: return VAL_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int unsigned pick_size();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return 2047;
			2: return 1024;
			3: return 1025;
			default: return $urandom_range(1, 7);
		endcase
	endfunction

	task automatic random_phase();
		int unsigned rows, cols, area, count;
		logic [VAL_W-1:0] px;
		rows = pick_size();
		cols = pick_size();
		set_config(rows, cols, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		area = sb.clamp_size(rows) * sb.clamp_size(cols);
		if (area > 64)
			count = $urandom_range(5, 60);
		else if ($urandom_range(0, 4) == 0)
			count = $urandom_range(1, area);
		else
			count = area * $urandom_range(1, 3);
		px = VAL_W'($urandom_range(0, 255));
		repeat (count) begin
			px = pick_pixel(px);
			send_pixel(px);
		end
	endtask

	initial begin
		#5000000;
		$display("testbench: FAIL");
		$finish;
	end

	initial begin
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= CFG_NUM_ROWS;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two one-pixel images after reset.
		send_pixel(8'h00);
		send_pixel(8'hFF);

		// Runs cut at every row end.
		set_config(2, 3, 0, 0);
		send_pixel(8'd5);
		send_pixel(8'd5);
		send_pixel(8'd7);
		send_pixel(8'd7);
		send_pixel(8'd7);
		send_pixel(8'd0);

		// Only zero runs gives a bare end marker; then the end flag lands on an earlier run.
		set_config(2, 2, 1, 1);
		repeat (4) send_pixel(8'd0);
		send_pixel(8'd0);
		send_pixel(8'd0);
		send_pixel(8'd9);
		send_pixel(8'd0);

		// Zero sizes act as one.
		set_config(0, 0, 1, 0);
		send_pixel(8'd0);

		// Shrinking the image while a row is in progress.
		set_config(3, 5, 0, 1);
		send_pixel(8'd1);
		send_pixel(8'd1);
		send_pixel(8'd2);
		set_config(3, 2, 0, 1);
		send_pixel(8'd2);
		set_config(1, 2, 0, 1);
		send_pixel(8'd2);
		send_pixel(8'd6);

		// Output held off long enough that the block fills and stalls its input.
		set_config(8, 1, 0, 0);
		hold_request = 1;
		wait (hold_active);
		repeat (24) send_pixel(VAL_W'($urandom_range(0, 255)));

		set_config(2047, 2047, 0, 1);
		repeat (20) send_pixel(VAL_W'($urandom_range(0, 255)));

		while (pixels_sent < PIXEL_TARGET) begin
			if (pixels_sent >= QUIET_AT)
				quiet = 1;
			random_phase();
		end
		wait_for_runs();

		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
